[rtl/core/iee_pkg.sv]
`default_nettype none

package iee_pkg;

  // width of the arithmetic words
  localparam int unsigned WordW = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned DivCntW = $clog2(WordW);

  // character codes
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_STAR  = 8'h2a;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2f;

  // pending operator codes
  typedef enum logic [2:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_TIMES = 3'd2,
    OP_DIV   = 3'd3,
    OP_DROP  = 3'd4
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // input transfer, latch item and extend number
    logic apply;     // apply pending operator (or start division)
    logic div_step;  // one restoring division step
    logic div_wb;    // write signed quotient and commit operator
    logic finish;    // load output register and clear state
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic needs_apply; // incoming item is neither digit nor space, or is the last one
    logic div_needed;  // pending divide with nonzero divisor
    logic last;        // latched item was the last one
    logic div_last;    // final division step this cycle
    logic out_free;    // output register can take a result
  } dp_stat_t;

  // map a character onto the operator it stands for
  function automatic op_t op_of_char(input logic [CharW-1:0] c);
    op_t op;
    unique case (c)
      CH_PLUS:  op = OP_PLUS;
      CH_MINUS: op = OP_MINUS;
      CH_STAR:  op = OP_TIMES;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_DROP;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

[rtl/core/iee_dpath.sv]
`default_nettype none

module iee_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire iee_pkg::dp_cmd_t           cmd,
  output iee_pkg::dp_stat_t               stat,
  input  wire logic [iee_pkg::CharW-1:0]  in_char,
  input  wire logic                       in_last,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [iee_pkg::WordW-1:0]       out_tdata,
  output logic                            out_tuser
);

  localparam int unsigned W = iee_pkg::WordW;

  // expression state
  logic [W-1:0]                 sum_r, sum_nxt;
  logic [W-1:0]                 term_r, term_nxt;
  logic [W-1:0]                 cur_r, cur_nxt;
  iee_pkg::op_t                 pend_r, pend_nxt;
  logic                         err_r, err_nxt;
  logic [iee_pkg::CharW-1:0]    char_r;
  logic                         last_r;

  // divider state
  logic [W-1:0]                 rem_r, rem_nxt;
  logic [W-1:0]                 quo_r, quo_nxt;
  logic [W-1:0]                 dvs_r, dvs_nxt;
  logic [iee_pkg::DivCntW-1:0]  cnt_r, cnt_nxt;
  logic                         qneg_r, qneg_nxt;

  // output register
  logic                         oval_r, oval_nxt;
  logic [W-1:0]                 odata_r;
  logic                         ouser_r;

  logic                         in_digit;
  logic [W-1:0]                 cur_ext;
  logic [W-1:0]                 prod_lo;
  logic [W:0]                   trial;
  logic [W-1:0]                 mag_a, mag_b;

  // incoming character classification and decimal shift
  assign in_digit = (in_char >= iee_pkg::CH_ZERO) && (in_char <= iee_pkg::CH_NINE);
  assign cur_ext  = (cur_r << 3) + (cur_r << 1) + {{(W-4){1'b0}}, in_char[3:0]};

  // low word of the product of open term and number
  assign prod_lo = term_r * cur_r;

  // divider operand magnitudes and trial subtract
  assign mag_a = term_r[W-1] ? (~term_r + 1'b1) : term_r;
  assign mag_b = cur_r[W-1]  ? (~cur_r + 1'b1)  : cur_r;
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};

  // status toward controller
  assign stat.needs_apply = (!in_digit && (in_char != iee_pkg::CH_SPACE)) || in_last;
  assign stat.div_needed  = (pend_r == iee_pkg::OP_DIV) && (cur_r != '0);
  assign stat.last        = last_r;
  assign stat.div_last    = (cnt_r == {iee_pkg::DivCntW{1'b1}});
  assign stat.out_free    = !oval_r || out_tready;

  // next state of expression and divider
  always_comb begin
    sum_nxt  = sum_r;
    term_nxt = term_r;
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    err_nxt  = err_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    qneg_nxt = qneg_r;
    oval_nxt = oval_r;

    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    if (cmd.accept && in_digit) begin
      cur_nxt = cur_ext;
    end

    if (cmd.apply) begin
      if (stat.div_needed) begin
        // load divider with magnitudes
        rem_nxt  = '0;
        quo_nxt  = mag_a;
        dvs_nxt  = mag_b;
        cnt_nxt  = '0;
        qneg_nxt = term_r[W-1] ^ cur_r[W-1];
      end else begin
        case (pend_r)
          iee_pkg::OP_PLUS: begin
            sum_nxt  = sum_r + term_r;
            term_nxt = cur_r;
          end
          iee_pkg::OP_MINUS: begin
            sum_nxt  = sum_r + term_r;
            term_nxt = ~cur_r + 1'b1;
          end
          iee_pkg::OP_TIMES: term_nxt = prod_lo;
          iee_pkg::OP_DIV: begin
            // division by zero
            term_nxt = '0;
            err_nxt  = 1'b1;
          end
          default: ;
        endcase
        pend_nxt = iee_pkg::op_of_char(char_r);
        cur_nxt  = '0;
      end
    end

    // one restoring step
    if (cmd.div_step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end

    if (cmd.div_wb) begin
      term_nxt = qneg_r ? (~quo_r + 1'b1) : quo_r;
      pend_nxt = iee_pkg::op_of_char(char_r);
      cur_nxt  = '0;
    end

    if (cmd.finish) begin
      oval_nxt = 1'b1;
      sum_nxt  = '0;
      term_nxt = '0;
      cur_nxt  = '0;
      pend_nxt = iee_pkg::OP_PLUS;
      err_nxt  = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      term_r <= '0;
      cur_r  <= '0;
      pend_r <= iee_pkg::OP_PLUS;
      err_r  <= 1'b0;
      oval_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      term_r <= term_nxt;
      cur_r  <= cur_nxt;
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
      oval_r <= oval_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    if (cmd.accept) begin
      char_r <= in_char;
      last_r <= in_last;
    end
    if (cmd.finish) begin
      odata_r <= sum_r + term_r;
      ouser_r <= err_r;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

`ifndef NO_ASSERTIONS
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!oval_r || out_tready))
    else $error("result loaded while output register still holds one");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dvs_r != '0))
    else $error("division step with zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (sum_r == '0 && term_r == '0 && !err_r && pend_r == iee_pkg::OP_PLUS))
    else $error("expression state not cleared after result");
`endif

endmodule

`default_nettype wire

[rtl/core/iee_ctrl.sv]
`default_nettype none

module iee_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire iee_pkg::dp_stat_t stat,
  output iee_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_APPLY = 5'b00010,
    S_DIV   = 5'b00100,
    S_DWB   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   xfer;

  assign in_tready = (state_r == S_IDLE);
  assign xfer      = in_tvalid && in_tready;

  // sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (xfer) begin
          cmd.accept = 1'b1;
          if (stat.needs_apply) state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (stat.div_needed)  state_nxt = S_DIV;
        else if (stat.last)   state_nxt = S_FIN;
        else                  state_nxt = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_DWB;
      end
      S_DWB: begin
        cmd.div_wb = 1'b1;
        state_nxt  = stat.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && $past(state_r) != S_DIV) |-> $past(stat.div_needed))
    else $error("division entered without a nonzero divisor");

  a_fin_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> stat.last)
    else $error("result stage reached for an item that is not last");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

[rtl/core/infix_expression_evaluator.sv]
// Digit or space that is not last: taken in S_IDLE, ready again next cycle.
// Operator or last character: S_APPLY follows; a divide with nonzero divisor goes
// on through load, 32 steps of the shared restoring divider and quotient write.
// Last character: S_FIN loads the output register once it is free; result appears
// on out_* the cycle after, held until taken. rst_n is synchronous, active low,
// and clears the expression state and the output valid flag.
`default_nettype none

module infix_expression_evaluator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] char_code
  input  wire logic                       in_tlast,   // last_char
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [iee_pkg::WordW-1:0]       out_tdata,  // [31:0] value
  output logic                            out_tuser   // [0] div_by_zero
);

  iee_pkg::dp_cmd_t  cmd;
  iee_pkg::dp_stat_t stat;

  // sequencer
  iee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and output register
  iee_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[bench/infix_expression_evaluator_tb.sv]
`default_nettype none

module infix_expression_evaluator_tb;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandChars = 1600;

  // one character on its way to the block
  typedef struct {
    logic [7:0] code;
    logic       is_last;
    int         gap;
    bit         drain_first;
  } char_item_t;

  // one expression result
  typedef struct packed {
    logic [iee_pkg::WordW-1:0] value;
    logic                      dbz;
  } eval_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = '0;   // [7:0] char_code
  logic                      in_tlast = 1'b0; // last_char
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [iee_pkg::WordW-1:0] out_tdata;       // [31:0] value
  logic                      out_tuser;       // [0] div_by_zero

  char_item_t   char_q[$];
  logic [7:0]   expr_chars[$];
  eval_result_t expr_results_q[$];

  // expression state of the predictor
  logic [iee_pkg::WordW-1:0] acc_sum = '0;
  logic [iee_pkg::WordW-1:0] open_term = '0;
  logic [iee_pkg::WordW-1:0] num_acc = '0;
  iee_pkg::op_t              next_op = iee_pkg::OP_PLUS;
  logic                      dbz_flag = 1'b0;

  bit          in_acc = 1'b0;
  int          gap_left = -1;
  int          rx_left = 0;
  int          rx_stall_pct = 20;
  int unsigned rx_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned chars_sent = 0;
  int unsigned results_seen = 0;
  int unsigned dbz_results = 0;
  int unsigned expr_count = 0;

  infix_expression_evaluator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // signed quotient, truncated toward zero, wrapping for the most negative over -1
  function automatic logic [iee_pkg::WordW-1:0] quot_toward_zero(
      input logic [iee_pkg::WordW-1:0] a,
      input logic [iee_pkg::WordW-1:0] b);
    logic [iee_pkg::WordW-1:0] ma;
    logic [iee_pkg::WordW-1:0] mb;
    logic [iee_pkg::WordW-1:0] q;
    ma = a[iee_pkg::WordW-1] ? -a : a;
    mb = b[iee_pkg::WordW-1] ? -b : b;
    q  = ma / mb;
    return (a[iee_pkg::WordW-1] ^ b[iee_pkg::WordW-1]) ? -q : q;
  endfunction

  // advance the expression state by one character, queue the result on the last
  task automatic eval_char(input logic [7:0] c, input logic is_last);
    logic is_digit;
    eval_result_t res;
    is_digit = (c >= iee_pkg::CH_ZERO) && (c <= iee_pkg::CH_NINE);
    if (is_digit) num_acc = num_acc * 32'd10 + 32'(c - iee_pkg::CH_ZERO);
    if ((!is_digit && c != iee_pkg::CH_SPACE) || is_last) begin
      case (next_op)
        iee_pkg::OP_PLUS: begin
          acc_sum   = acc_sum + open_term;
          open_term = num_acc;
        end
        iee_pkg::OP_MINUS: begin
          acc_sum   = acc_sum + open_term;
          open_term = -num_acc;
        end
        iee_pkg::OP_TIMES: open_term = open_term * num_acc;
        iee_pkg::OP_DIV: begin
          if (num_acc == '0) begin
            open_term = '0;
            dbz_flag  = 1'b1;
          end else begin
            open_term = quot_toward_zero(open_term, num_acc);
          end
        end
        default: ;
      endcase
      case (c)
        iee_pkg::CH_PLUS:  next_op = iee_pkg::OP_PLUS;
        iee_pkg::CH_MINUS: next_op = iee_pkg::OP_MINUS;
        iee_pkg::CH_STAR:  next_op = iee_pkg::OP_TIMES;
        iee_pkg::CH_SLASH: next_op = iee_pkg::OP_DIV;
        default:           next_op = iee_pkg::OP_DROP;
      endcase
      num_acc = '0;
    end
    if (is_last) begin
      res.value = acc_sum + open_term;
      res.dbz   = dbz_flag;
      expr_results_q.push_back(res);
      acc_sum   = '0;
      open_term = '0;
      num_acc   = '0;
      next_op   = iee_pkg::OP_PLUS;
      dbz_flag  = 1'b0;
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  // move the built expression into the stimulus queue, flag on the final char
  task automatic commit_expr(input bit drain, input bit dense);
    char_item_t it;
    int n;
    n = expr_chars.size();
    for (int i = 0; i < n; i++) begin
      it.code        = expr_chars[i];
      it.is_last     = (i == n - 1);
      it.gap         = dense ? 0 : pick_gap();
      it.drain_first = drain && (i == 0);
      char_q.push_back(it);
    end
    expr_chars.delete();
    expr_count++;
  endtask

  // operands: mostly short, some full width, some past 32 bits
  task automatic put_number();
    int r;
    int nd;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 92) begin
      if (r < 60) n = $urandom_range(0, 99);
      else if (r < 80) n = $urandom_range(0, 99999);
      else n = $urandom();
      put_str($sformatf("%0d", n));
    end else if (r < 96) begin
      case ($urandom_range(0, 2))
        0: put_str("4294967295");
        1: put_str("2147483648");
        default: put_str("2147483647");
      endcase
    end else begin
      nd = $urandom_range(11, 13);
      for (int i = 0; i < nd; i++) begin
        expr_chars.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
  endtask

  task automatic put_op();
    case ($urandom_range(0, 3))
      0: expr_chars.push_back(iee_pkg::CH_PLUS);
      1: expr_chars.push_back(iee_pkg::CH_MINUS);
      2: expr_chars.push_back(iee_pkg::CH_STAR);
      default: expr_chars.push_back(iee_pkg::CH_SLASH);
    endcase
  endtask

  // one random expression: well formed mostly, some noise and odd shapes
  task automatic gen_expr();
    int r;
    int nterms;
    bit after_div;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // noise of arbitrary bytes
      nterms = $urandom_range(1, 6);
      for (int i = 0; i < nterms; i++) expr_chars.push_back(8'($urandom_range(0, 255)));
    end else if (r < 8) begin
      // most negative value divided by minus one
      if ($urandom_range(0, 1) == 0) put_str("65536*32768/4294967295");
      else put_str("-2147483648/4294967295");
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) expr_chars.push_back(iee_pkg::CH_MINUS);
      else if (r < 11) expr_chars.push_back(iee_pkg::CH_STAR);
      else if (r < 14) expr_chars.push_back(iee_pkg::CH_SLASH);
      else if (r < 18) expr_chars.push_back(iee_pkg::CH_SPACE);
      after_div = 1'b0;
      nterms = $urandom_range(1, 5);
      for (int t = 0; t < nterms; t++) begin
        if ($urandom_range(0, 9) == 0) expr_chars.push_back(iee_pkg::CH_SPACE);
        if (after_div && $urandom_range(0, 9) == 0) expr_chars.push_back(iee_pkg::CH_ZERO);
        else put_number();
        if ($urandom_range(0, 9) == 0) expr_chars.push_back(iee_pkg::CH_SPACE);
        after_div = 1'b0;
        if (t < nterms - 1) begin
          if ($urandom_range(0, 99) < 4) begin
            expr_chars.push_back(8'($urandom_range(0, 255)));
          end else begin
            put_op();
            after_div = (expr_chars[expr_chars.size() - 1] == iee_pkg::CH_SLASH);
          end
        end
      end
      r = $urandom_range(0, 99);
      if (r < 6) put_op();
      else if (r < 12) expr_chars.push_back(iee_pkg::CH_SPACE);
    end
  endtask

  // stimulus build, end of run
  initial begin
    int total;
    bit dense;
    // directed: divide by zero, leading times with space last, unknown bytes,
    // truncation toward zero, single digit, wrap of the sum
    put_str("7/0");
    commit_expr(1'b0, 1'b0);
    put_str("*5-9 ");
    commit_expr(1'b0, 1'b1);
    expr_chars.push_back(8'hff);
    put_str("3+");
    expr_chars.push_back(8'h00);
    commit_expr(1'b0, 1'b0);
    put_str("-7/2");
    commit_expr(1'b0, 1'b1);
    put_str("9");
    commit_expr(1'b0, 1'b0);
    put_str("2147483647+1");
    commit_expr(1'b0, 1'b1);

    total = 0;
    dense = 1'b0;
    for (int e = 0; total < RandChars; e++) begin
      if (e % 30 == 0) dense = ($urandom_range(0, 2) == 0);
      gen_expr();
      total += expr_chars.size();
      commit_expr(e % 60 == 0, dense);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_tvalid || expr_results_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d characters in %0d expressions, %0d results checked",
             chars_sent, expr_count, results_seen);
    $display("%0d results carried the divide by zero flag", dbz_results);
    if (err_cnt == 0) begin
      $display("infix_expression_evaluator verification clean");
    end else begin
      $display("infix_expression_evaluator verification failed");
    end
    $finish;
  end

  // input driver, holds each character until its transfer
  always @(negedge clk) begin
    logic       nxt_valid;
    char_item_t it;
    if (rst_n && !(in_tvalid && !in_acc)) begin
      nxt_valid = 1'b0;
      if (char_q.size() > 0) begin
        if (gap_left < 0) gap_left = char_q[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(char_q[0].drain_first && expr_results_q.size() > 0)) begin
          it        = char_q.pop_front();
          gap_left  = -1;
          nxt_valid = 1'b1;
          in_tdata <= it.code;
          in_tlast <= it.is_last;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // result side back pressure, with phases of no stalls
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycles++;
      if (rx_cycles % 1500 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 20;
          default: rx_stall_pct = 50;
        endcase
      end
      if (rx_left > 0) begin
        rx_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        rx_left = pick_gap();
        out_tready <= (rx_left == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from accepted characters
  always @(posedge clk) begin
    eval_result_t exp_res;
    in_acc = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) dbz_results++;
      if (expr_results_q.size() == 0) begin
        $error("result with no expression pending: value %0d div_by_zero %0b",
               $signed(out_tdata), out_tuser);
        err_cnt++;
      end else begin
        exp_res = expr_results_q.pop_front();
        if (out_tdata !== exp_res.value) begin
          $error("value: expected %0d, got %0d", $signed(exp_res.value), $signed(out_tdata));
          err_cnt++;
        end
        if (out_tuser !== exp_res.dbz) begin
          $error("div_by_zero: expected %0b, got %0b", exp_res.dbz, out_tuser);
          err_cnt++;
        end
      end
    end
    if (in_acc) begin
      chars_sent++;
      eval_char(in_tdata, in_tlast);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("infix_expression_evaluator verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
